### hdl/mbrs_pkg.sv
// Shared types, constants and CRC helper for the Modbus RTU register slave.
package mbrs_pkg;

  // Default sizes
  localparam int unsigned RX_DEPTH_DEF      = 64;
  localparam int unsigned FRAME_LIMIT_DEF   = 32;
  localparam int unsigned REG_COUNT_DEF     = 32;
  localparam int unsigned MAX_READ_REGS_DEF = 13;

  // Input operations
  localparam logic [1:0] OP_RX_BYTE = 2'd0;
  localparam logic [1:0] OP_TICK    = 2'd1;
  localparam logic [1:0] OP_LOAD    = 2'd2;
  localparam logic [1:0] OP_NONE    = 2'd3;

  // Configuration register indexes
  localparam logic [1:0] CFG_SLAVE_ADDR = 2'd0;
  localparam logic [1:0] CFG_IDLE_LIMIT = 2'd1;
  localparam logic [1:0] CFG_HIGH_REG   = 2'd2;
  localparam logic [1:0] CFG_UNUSED     = 2'd3;

  // Configuration reset values
  localparam logic [7:0] SLAVE_ADDR_RST = 8'h01;
  localparam logic [7:0] IDLE_LIMIT_RST = 8'd5;
  localparam logic [4:0] HIGH_REG_RST   = 5'd4;

  // Modbus codes
  localparam logic [7:0] FC_READ          = 8'h03;
  localparam logic [7:0] FC_WRITE         = 8'h06;
  localparam logic [7:0] FC_EXC_FLAG      = 8'h80;
  localparam logic [7:0] EXC_ILLEGAL_FN   = 8'h01;
  localparam logic [7:0] EXC_ILLEGAL_ADDR = 8'h02;
  localparam int unsigned MIN_FRAME       = 4;

  typedef struct packed {
    logic [1:0]  opcode;
    logic [7:0]  rx_byte;
    logic [7:0]  elapsed_ms;
    logic [4:0]  load_index;
    logic [15:0] load_value;
  } in_item_t;

  typedef struct packed {
    logic [7:0] tx_byte;
    logic       last;
  } out_item_t;

  // CRC-16/MODBUS over one byte, reflected poly 0xA001
  function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {8'h00, b};
    for (int i = 0; i < 8; i++) begin
      c = c[0] ? ((c >> 1) ^ 16'hA001) : (c >> 1);
    end
    return c;
  endfunction

endpackage

### hdl/modbus_rtu_register_slave.sv
// Top level of the Modbus RTU register slave: frame timing, check and reply sequencer.
//
// Input channel: an item (received byte, timer tick or holding register load)
// transfers at a clock edge with start high and busy low. A tick that reaches
// the idle limit ends the frame: busy then stays high while the frame is copied
// out of the receive RAM (CRC checked on the way), a check state follows, and
// the reply is sent back byte by byte (one RAM read, one byte out).
// Result channel: out_valid strobes for one cycle per reply byte, out_data.last
// on the final CRC byte. The receiver cannot stall; bytes are never held.
// A wrong slave address, bad CRC or frames under four bytes end with no reply.
// Configuration: cfg_valid/cfg_ready with cfg_index, always ready; writes are
// expected only while idle.
// Reset (synchronous, rst_n low): configuration to defaults, counters cleared,
// holding registers read as zero through per-entry valid bits. The receive
// RAM needs no clearing: only written entries are ever read.
module modbus_rtu_register_slave import mbrs_pkg::*; #(
  parameter int unsigned RX_DEPTH      = RX_DEPTH_DEF,
  parameter int unsigned FRAME_LIMIT   = FRAME_LIMIT_DEF,
  parameter int unsigned REG_COUNT     = REG_COUNT_DEF,
  parameter int unsigned MAX_READ_REGS = MAX_READ_REGS_DEF
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      start,
  output logic      busy,
  input  in_item_t  in_data,
  output logic      out_valid,
  output out_item_t out_data,
  input  logic      cfg_valid,
  output logic      cfg_ready,
  input  logic [1:0] cfg_index,
  input  logic [7:0] cfg_data
);

  localparam int unsigned RX_AW  = $clog2(RX_DEPTH);
  localparam int unsigned RXC_W  = $clog2(RX_DEPTH + 1);
  localparam int unsigned CNT_W  = $clog2(FRAME_LIMIT + 1);
  localparam int unsigned REG_AW = $clog2(REG_COUNT);
  localparam int unsigned FIT_REGS = (FRAME_LIMIT - 5) / 2;
  localparam int unsigned CNT_CAP  = (MAX_READ_REGS < FIT_REGS) ? MAX_READ_REGS : FIT_REGS;

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_COPY  = 3'd1;
  localparam logic [2:0] ST_CHECK = 3'd2;
  localparam logic [2:0] ST_FETCH = 3'd3;
  localparam logic [2:0] ST_EMIT  = 3'd4;

  // Reduce a small register number modulo REG_COUNT (value below 32, by repeated subtraction)
  function automatic logic [REG_AW-1:0] reg_wrap(input logic [4:0] v);
    logic [8:0] t;
    t = {4'd0, v};
    for (int i = 0; i < 4; i++) begin
      if (t >= 9'(REG_COUNT)) t = t - 9'(REG_COUNT);
    end
    return REG_AW'(t);
  endfunction

  // Configuration
  logic [7:0] slave_addr_r, idle_limit_r;
  logic [4:0] high_reg_r;

  // Control state
  logic [2:0]       state_r;
  logic [RXC_W-1:0] rx_count_r, snap_r;
  logic [7:0]       idle_r;
  logic [CNT_W-1:0] len_r, rd_idx_r, cp_idx_r, e_r, body_r;
  logic             cp_vld_r;
  logic [15:0]      crc_r;
  logic [7:0]       rx_crc_lo_r, rx_crc_hi_r;
  logic             is_echo_r, is_read_r;
  logic [7:0]       hdr1_r, hdr2_r;
  logic [REG_AW-1:0] ptr_r;
  logic [REG_COUNT-1:0] hvalid_r;
  logic             hok_r;
  logic [7:0]       sh_r [6];    // first six bytes of the request, then of the reply
  logic             out_valid_r;
  out_item_t        out_data_r;

  logic accept;
  assign accept    = start && !busy;
  assign busy      = (state_r != ST_IDLE);
  assign cfg_ready = 1'b1;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // Receive RAM
  logic             rx_we;
  logic [RX_AW-1:0] rx_raddr;
  logic [7:0]       rx_rdata;

  assign rx_we    = accept && in_data.opcode == OP_RX_BYTE &&
                    32'(rx_count_r) < RX_DEPTH;
  assign rx_raddr = (state_r == ST_COPY) ? RX_AW'(rd_idx_r) : RX_AW'(e_r);

  mbrs_ram #(.W(8), .D(RX_DEPTH)) u_rx_ram (
    .clk   (clk),
    .we    (rx_we),
    .waddr (RX_AW'(rx_count_r)),
    .wdata (in_data.rx_byte),
    .raddr (rx_raddr),
    .rdata (rx_rdata)
  );

  // Holding register RAM: loads in idle, function 6 write in the check cycle
  logic              load_we, fn6_we, h_we;
  logic [REG_AW-1:0] h_waddr;
  logic [15:0]       h_wdata, h_rdata;

  // Frame decision terms
  logic       frame_ok, addr_ok;
  logic [7:0] cnt;
  assign addr_ok  = (sh_r[2] == 8'h00) && (sh_r[3] <= {3'd0, high_reg_r});
  assign frame_ok = (32'(len_r) >= MIN_FRAME) && (sh_r[0] == slave_addr_r) &&
                    (crc_r == {rx_crc_hi_r, rx_crc_lo_r});
  assign cnt      = (32'(sh_r[5]) > CNT_CAP) ? 8'(CNT_CAP) : sh_r[5];

  assign load_we = accept && in_data.opcode == OP_LOAD &&
                   {4'd0, in_data.load_index} < 9'(REG_COUNT);
  assign fn6_we  = state_r == ST_CHECK && frame_ok && sh_r[1] == FC_WRITE && addr_ok;
  assign h_we    = load_we || fn6_we;
  assign h_waddr = fn6_we ? reg_wrap(sh_r[3][4:0]) : REG_AW'(in_data.load_index);
  assign h_wdata = fn6_we ? {8'h00, sh_r[5]} : in_data.load_value;

  mbrs_ram #(.W(16), .D(REG_COUNT)) u_hold_ram (
    .clk   (clk),
    .we    (h_we),
    .waddr (h_waddr),
    .wdata (h_wdata),
    .raddr (ptr_r),
    .rdata (h_rdata)
  );

  // Tick handling
  logic [8:0] idle_sum;
  logic [7:0] idle_sat;
  logic       frame_end;
  assign idle_sum  = {1'b0, idle_r} + {1'b0, in_data.elapsed_ms};
  assign idle_sat  = idle_sum[8] ? 8'hFF : idle_sum[7:0];
  assign frame_end = accept && in_data.opcode == OP_TICK && rx_count_r != '0 &&
                     snap_r == rx_count_r && idle_r < idle_limit_r &&
                     idle_sat >= idle_limit_r;

  // Reply byte selection
  logic [15:0] h_word;
  logic [7:0]  body_byte, tx_b;
  logic        in_body, is_last;
  assign h_word  = hok_r ? h_rdata : 16'h0000;
  assign in_body = e_r < body_r;
  assign is_last = {1'b0, e_r} == {1'b0, body_r} + (CNT_W+1)'(1);
  always_comb begin
    if (is_echo_r) begin
      body_byte = rx_rdata;
    end else if (e_r == CNT_W'(0)) begin
      body_byte = sh_r[0];
    end else if (e_r == CNT_W'(1)) begin
      body_byte = hdr1_r;
    end else if (e_r == CNT_W'(2)) begin
      body_byte = hdr2_r;
    end else begin
      body_byte = e_r[0] ? h_word[15:8] : h_word[7:0];
    end
    if (in_body) begin
      tx_b = body_byte;
    end else if (is_last) begin
      tx_b = crc_r[15:8];
    end else begin
      tx_b = crc_r[7:0];
    end
  end

  // Copy-phase terms
  logic cp_in_crc, cp_is_lo, cp_is_hi, cp_done;
  assign cp_in_crc = ({1'b0, cp_idx_r} + (CNT_W+1)'(2)) <  {1'b0, len_r};
  assign cp_is_lo  = ({1'b0, cp_idx_r} + (CNT_W+1)'(2)) == {1'b0, len_r};
  assign cp_is_hi  = ({1'b0, cp_idx_r} + (CNT_W+1)'(1)) == {1'b0, len_r};
  assign cp_done   = cp_is_hi;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      slave_addr_r <= SLAVE_ADDR_RST;
      idle_limit_r <= IDLE_LIMIT_RST;
      high_reg_r   <= HIGH_REG_RST;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_SLAVE_ADDR: slave_addr_r <= cfg_data;
        CFG_IDLE_LIMIT: idle_limit_r <= cfg_data;
        CFG_HIGH_REG:   high_reg_r   <= cfg_data[4:0];
        CFG_UNUSED:     ;
      endcase
    end
  end

  // Holding register valid bits; hok_r follows the read data
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hvalid_r <= '0;
    end else if (h_we) begin
      hvalid_r[h_waddr] <= 1'b1;
    end
    hok_r <= hvalid_r[ptr_r];
  end

  // Sequencer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      rx_count_r  <= '0;
      snap_r      <= '0;
      idle_r      <= '0;
      cp_vld_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= (state_r == ST_EMIT);
      unique case (state_r)
        ST_IDLE: begin
          if (accept) begin
            unique case (in_data.opcode)
              OP_RX_BYTE: begin
                if (rx_we) rx_count_r <= rx_count_r + RXC_W'(1);
              end
              OP_TICK: begin
                if (rx_count_r == '0) begin
                  snap_r <= '0;
                end else if (snap_r != rx_count_r) begin
                  snap_r <= rx_count_r;
                  idle_r <= '0;
                end else if (idle_r < idle_limit_r) begin
                  idle_r <= idle_sat;
                end
                if (frame_end) begin
                  len_r      <= (32'(rx_count_r) < FRAME_LIMIT) ?
                                CNT_W'(rx_count_r) : CNT_W'(FRAME_LIMIT);
                  rx_count_r <= '0;
                  rd_idx_r   <= '0;
                  crc_r      <= 16'hFFFF;
                  cp_vld_r   <= 1'b0;
                  state_r    <= ST_COPY;
                end
              end
              OP_LOAD, OP_NONE: ;
            endcase
          end
        end
        ST_COPY: begin
          // read data arrives the cycle after its address; stop once the last byte lands
          cp_vld_r <= (rd_idx_r != len_r) && !(cp_vld_r && cp_done);
          cp_idx_r <= rd_idx_r;
          if (rd_idx_r != len_r) rd_idx_r <= rd_idx_r + CNT_W'(1);
          if (cp_vld_r) begin
            if (cp_idx_r < CNT_W'(6)) sh_r[cp_idx_r[2:0]] <= rx_rdata;
            if (cp_in_crc) crc_r <= crc_byte(crc_r, rx_rdata);
            if (cp_is_lo)  rx_crc_lo_r <= rx_rdata;
            if (cp_is_hi)  rx_crc_hi_r <= rx_rdata;
            if (cp_done) begin
              state_r  <= ST_CHECK;
            end
          end
        end
        ST_CHECK: begin
          crc_r     <= 16'hFFFF;
          e_r       <= '0;
          ptr_r     <= reg_wrap(sh_r[3][4:0]);
          is_echo_r <= frame_ok && sh_r[1] == FC_WRITE && addr_ok;
          is_read_r <= frame_ok && sh_r[1] == FC_READ && addr_ok;
          if (!frame_ok) begin
            state_r <= ST_IDLE;
          end else begin
            state_r <= ST_FETCH;
            priority if (sh_r[1] == FC_READ && addr_ok) begin
              hdr1_r    <= FC_READ;
              hdr2_r    <= 8'({cnt, 1'b0});
              body_r    <= CNT_W'(9'd3 + {cnt, 1'b0});
            end else if (sh_r[1] == FC_WRITE && addr_ok) begin
              body_r    <= len_r - CNT_W'(2);
            end else if (sh_r[1] == FC_READ || sh_r[1] == FC_WRITE) begin
              hdr1_r <= sh_r[1] | FC_EXC_FLAG;
              hdr2_r <= EXC_ILLEGAL_ADDR;
              body_r <= CNT_W'(3);
            end else begin
              hdr1_r <= FC_EXC_FLAG;
              hdr2_r <= EXC_ILLEGAL_FN;
              body_r <= CNT_W'(3);
            end
          end
        end
        ST_FETCH: begin
          state_r <= ST_EMIT;
        end
        ST_EMIT: begin
          out_data_r.tx_byte  <= tx_b;
          out_data_r.last     <= is_last;
          if (e_r < CNT_W'(6)) sh_r[e_r[2:0]] <= tx_b;
          if (in_body) crc_r <= crc_byte(crc_r, tx_b);
          // advance register pointer after each low byte of read data
          if (is_read_r && in_body && e_r >= CNT_W'(4) && !e_r[0]) begin
            ptr_r <= (32'(ptr_r) == REG_COUNT - 1) ? '0 : ptr_r + REG_AW'(1);
          end
          e_r     <= e_r + CNT_W'(1);
          state_r <= is_last ? ST_IDLE : ST_FETCH;
        end
        default: state_r <= ST_IDLE;
      endcase
    end
  end

`ifndef ASSERT_OFF
  a_strobe_gap: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |=> !out_valid_r)
    else $error("reply bytes on consecutive cycles");
  a_rx_bound: assert property (@(posedge clk) disable iff (!rst_n)
    32'(rx_count_r) <= RX_DEPTH)
    else $error("receive count beyond buffer depth");
  a_check_after_copy: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_CHECK |-> $past(state_r) == ST_COPY)
    else $error("check entered without copy");
  a_copy_index: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_COPY && cp_vld_r |-> cp_idx_r < len_r)
    else $error("copy index beyond frame length");
`endif

endmodule

### hdl/mbrs_ram.sv
// Generic single-write, single-read synchronous RAM with registered read data.
module mbrs_ram import mbrs_pkg::*; #(
  parameter int unsigned W  = 8,
  parameter int unsigned D  = 64,
  parameter int unsigned AW = $clog2(D)
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [W-1:0]  wdata,
  input  logic [AW-1:0] raddr,
  output logic [W-1:0]  rdata
);

  logic [W-1:0] mem [D];
  logic [W-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule
